[design/cdsg_pkg.sv]
package cdsg_pkg;

   // Fixed field widths
   localparam int COORD_W    = 16;
   localparam int RADIUS_W   = 5;
   localparam int COST_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_RADIUS = 31;
   localparam int DEF_COORD_BITS = 16;

   // Cost saturation limit
   localparam logic [COST_W-1:0] COST_MAX = 8'd254;

   // Register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd11;
   localparam logic [COORD_W-1:0]  BOUND_RESET  = 16'hFFFF;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS      = 3'd0,
      CSR_WIN_X_LOW   = 3'd1,
      CSR_WIN_Y_LOW   = 3'd2,
      CSR_WIN_X_HIGH  = 3'd3,
      CSR_WIN_Y_HIGH  = 3'd4,
      CSR_GRID_WIDTH  = 3'd5,
      CSR_GRID_HEIGHT = 3'd6,
      CSR_COST        = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] row_index;
      logic [COORD_W-1:0] first_column;
      logic [COORD_W-1:0] final_column;
      logic [COST_W-1:0]  cell_cost;
      logic               end_of_run;
   } rsp_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [RADIUS_W-1:0] disk_radius;
      logic [COORD_W-1:0]  window_x_low;
      logic [COORD_W-1:0]  window_y_low;
      logic [COORD_W-1:0]  window_x_high;
      logic [COORD_W-1:0]  window_y_high;
      logic [COORD_W-1:0]  grid_width;
      logic [COORD_W-1:0]  grid_height;
      logic [COST_W-1:0]   cost_value;
   } cfg_type;

   // One clipped row span
   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] first_col;
      logic [COORD_W-1:0] final_col;
   } span_type;

endpackage

[design/clipped_disk_span_generator_core.sv]
// Clipped disk span generator. Pulse start while busy is low to hand in one
// obstacle centre; the block then walks the disk rows top to bottom and puts
// out one clipped span per nonempty row on rsp_data, each marked by a
// one-cycle rsp_valid strobe, the last with end_of_run set. The receiver
// cannot stall, so every strobe must be taken when it appears. One shared
// squarer drives the walk: the half-width moves by one cell per cycle, and each
// row takes an offset square, one or more half-width tests and a clip, in that
// order. Spans leave one row late because each is held until the next one
// settles end_of_run; the final span appears in the cycle busy drops.
// Configuration writes belong to idle periods.
module clipped_disk_span_generator_core
   import cdsg_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RAD_BITS = (MAX_RADIUS < 2) ? 1 : $clog2(MAX_RADIUS + 1);
   localparam int OP_W     = RAD_BITS + 1;
   localparam int SQ_W     = 2 * OP_W;
   localparam int DY_W     = RAD_BITS + 1;
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RSQ,
      ST_DSQ,
      ST_ADJ,
      ST_SPAN,
      ST_FLUSH
   } state_type;

   cfg_type             cfg;
   span_type            span;
   state_type           state_ff, state_in;
   logic [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_BITS-1:0] r_ff, r_in, h_ff, h_in;
   logic [SQ_W-1:0]     r2_ff, r2_in, limit_ff, limit_in;
   logic signed [DY_W-1:0] dy_ff, dy_in, r_signed;
   logic                pend_valid_ff, pend_valid_in;
   rsp_type             pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [OP_W-1:0]     operand, ady;
   logic [SQ_W-1:0]     square;
   logic                top_half;
   logic [RADIUS_W-1:0] rad_raw;
   logic [RAD_BITS-1:0] rad_sat;

   cdsg_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   cdsg_square_unit #(
      .OP_W (OP_W)
   ) u_square (
      .operand (operand),
      .square  (square)
   );

   cdsg_span_clip #(
      .DY_W (DY_W),
      .H_W  (RAD_BITS)
   ) u_clip (
      .cfg      (cfg),
      .center_x (cx_ff),
      .center_y (cy_ff),
      .dy       (dy_ff),
      .half     (h_ff),
      .span     (span)
   );

   // Radius clamped to 1..MAX_RADIUS
   assign rad_raw = cfg.disk_radius;
   always_comb begin
      if (rad_raw == '0) begin
         rad_sat = RAD_BITS'(1);
      end else if (rad_raw > RADIUS_W'(MAX_RADIUS)) begin
         rad_sat = RAD_BITS'(MAX_RADIUS);
      end else begin
         rad_sat = RAD_BITS'(rad_raw);
      end
   end

   // Row offset magnitude and walk direction
   assign r_signed = $signed({1'b0, r_ff});
   assign ady      = dy_ff[DY_W-1] ? OP_W'(-dy_ff) : OP_W'(dy_ff);
   assign top_half = dy_ff[DY_W-1] || (dy_ff == '0);

   // Squarer operand select
   always_comb begin
      case (state_ff)
         ST_RSQ:  operand = OP_W'(r_ff);
         ST_DSQ:  operand = ady;
         ST_ADJ:  operand = top_half ? (OP_W'(h_ff) + OP_W'(1)) : OP_W'(h_ff);
         default: operand = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      r_in          = r_ff;
      h_in          = h_ff;
      r2_in         = r2_ff;
      limit_in      = limit_ff;
      dy_in         = dy_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cx_in         = req_data.center_x & COORD_MASK;
               cy_in         = req_data.center_y & COORD_MASK;
               r_in          = rad_sat;
               h_in          = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_RSQ;
            end
         end
         ST_RSQ: begin
            r2_in    = square;
            dy_in    = -r_signed;
            state_in = ST_DSQ;
         end
         ST_DSQ: begin
            limit_in = r2_ff - square;
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            // Half-width grows on the upper half, shrinks on the lower half
            if (top_half) begin
               if (square <= limit_ff) begin
                  h_in = h_ff + RAD_BITS'(1);
               end else begin
                  state_in = ST_SPAN;
               end
            end else begin
               if (square > limit_ff) begin
                  h_in = h_ff - RAD_BITS'(1);
               end else begin
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            if (span.hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_valid_in        = 1'b1;
               pend_in.row_index    = span.row;
               pend_in.first_column = span.first_col;
               pend_in.final_column = span.final_col;
               pend_in.cell_cost    = cfg.cost_value;
               pend_in.end_of_run   = 1'b0;
            end
            if (dy_ff == r_signed) begin
               state_in = ST_FLUSH;
            end else begin
               dy_in    = dy_ff + DY_W'(1);
               state_in = ST_DSQ;
            end
         end
         ST_FLUSH: begin
            // Held span is the last one of the run
            if (pend_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = pend_ff;
               rsp_in.end_of_run  = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      r_ff     <= r_in;
      h_ff     <= h_in;
      r2_ff    <= r2_in;
      limit_ff <= limit_in;
      dy_ff    <= dy_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/cdsg_csr.sv]
module cdsg_csr
   import cdsg_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

   cfg_type cfg_ff, cfg_in;
   logic [COORD_W-1:0] coord_val;
   logic [COST_W-1:0]  cost_raw;

   assign coord_val = csr_wdata[COORD_W-1:0] & COORD_MASK;
   assign cost_raw  = csr_wdata[COST_W-1:0];

   // Register write decode with masking and cost saturation
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_RADIUS:      cfg_in.disk_radius   = csr_wdata[RADIUS_W-1:0];
            CSR_WIN_X_LOW:   cfg_in.window_x_low  = coord_val;
            CSR_WIN_Y_LOW:   cfg_in.window_y_low  = coord_val;
            CSR_WIN_X_HIGH:  cfg_in.window_x_high = coord_val;
            CSR_WIN_Y_HIGH:  cfg_in.window_y_high = coord_val;
            CSR_GRID_WIDTH:  cfg_in.grid_width    = coord_val;
            CSR_GRID_HEIGHT: cfg_in.grid_height   = coord_val;
            CSR_COST:        cfg_in.cost_value    = (cost_raw > COST_MAX) ? COST_MAX : cost_raw;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_radius   <= RADIUS_RESET;
         cfg_ff.window_x_low  <= '0;
         cfg_ff.window_y_low  <= '0;
         cfg_ff.window_x_high <= BOUND_RESET & COORD_MASK;
         cfg_ff.window_y_high <= BOUND_RESET & COORD_MASK;
         cfg_ff.grid_width    <= BOUND_RESET & COORD_MASK;
         cfg_ff.grid_height   <= BOUND_RESET & COORD_MASK;
         cfg_ff.cost_value    <= COST_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/cdsg_square_unit.sv]
module cdsg_square_unit
   import cdsg_pkg::*;
#(
   parameter int OP_W = 6
) (
   input  logic [OP_W-1:0]   operand,
   output logic [2*OP_W-1:0] square
);

   // Shared squarer: radius, row offset and half-width tests all go through here
   assign square = (2*OP_W)'(operand) * (2*OP_W)'(operand);

endmodule

[design/cdsg_span_clip.sv]
module cdsg_span_clip
   import cdsg_pkg::*;
#(
   parameter int DY_W = 6,
   parameter int H_W  = 5
) (
   input  cfg_type                cfg,
   input  logic [COORD_W-1:0]     center_x,
   input  logic [COORD_W-1:0]     center_y,
   input  logic signed [DY_W-1:0] dy,
   input  logic [H_W-1:0]         half,
   output span_type               span
);

   localparam int SW = COORD_W + 2;

   logic [COORD_W-1:0]   row_bound, col_bound;
   logic signed [SW-1:0] row, row_lo, row_hi, col_lo, col_hi_m1;
   logic signed [SW-1:0] cx, h_s, left, right, first_col, final_col;
   logic                 row_ok;

   // Exclusive bounds are the tighter of window and grid
   assign row_bound = (cfg.window_y_high < cfg.grid_height) ? cfg.window_y_high : cfg.grid_height;
   assign col_bound = (cfg.window_x_high < cfg.grid_width)  ? cfg.window_x_high : cfg.grid_width;

   assign row_lo    = $signed({2'b00, cfg.window_y_low});
   assign row_hi    = $signed({2'b00, row_bound});
   assign col_lo    = $signed({2'b00, cfg.window_x_low});
   assign col_hi_m1 = $signed({2'b00, col_bound}) - SW'(1);

   // Row check
   assign row    = $signed({2'b00, center_y}) + SW'(dy);
   assign row_ok = !row[SW-1] && (row >= row_lo) && (row < row_hi);

   // Column span; window low bound is never negative, so it also covers column zero
   assign cx        = $signed({2'b00, center_x});
   assign h_s       = $signed(SW'(half));
   assign left      = cx - h_s;
   assign right     = cx + h_s;
   assign first_col = (left > col_lo) ? left : col_lo;
   assign final_col = (right < col_hi_m1) ? right : col_hi_m1;

   assign span.hit       = row_ok && (first_col <= final_col);
   assign span.row       = row[COORD_W-1:0];
   assign span.first_col = first_col[COORD_W-1:0];
   assign span.final_col = final_col[COORD_W-1:0];

endmodule

[design/cdsg_checker.sv]
module cdsg_checker
   import cdsg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("span strobe right after reset");

   // An accepted obstacle makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after transfer");

   // Inner spans only appear while the walk is running
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.end_of_run) |-> busy)
      else $error("inner span while idle");

   // The closing span coincides with the return to idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_run) |-> !busy)
      else $error("closing span while still busy");

   // Nothing follows the closing span in the next cycle
   a_end_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_run) |=> !rsp_valid)
      else $error("span right after closing span");

endmodule

bind clipped_disk_span_generator_core cdsg_checker u_cdsg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
